@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the clocked checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge outside reset
`define SSSD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// ante at one edge forces cons at the next edge
`define SSSD_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/sssd_pkg.sv @@
// ---------------------------------------------------------------------------
// sssd_pkg
// Shared types, codes and the numeral font of the scan driver.
// ---------------------------------------------------------------------------
`default_nettype none

package sssd_pkg;

	localparam int MAX_DIGITS = 8;
	localparam int POS_W      = 3;
	localparam int PERIOD_W   = 20;
	localparam int MASK_W     = 8;
	localparam int ELAPSED_W  = 21;
	localparam int CONV_W     = 27;   // 99999999 fits in 27 bits
	localparam int BCD_W      = 4 * MAX_DIGITS;
	localparam int STEP_W     = 5;
	localparam int WORD_W     = 16;
	localparam int BITCNT_W   = 4;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_INT  = 2'd1;
	localparam logic [1:0] OP_DIG  = 2'd2;

	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_MASK   = 1'b1;

	localparam logic [7:0] SEG_O    = 8'h3F;
	localparam logic [7:0] SEG_L    = 8'h38;
	localparam logic [7:0] SEG_DASH = 8'h40;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	typedef logic [7:0] seg_t;

	typedef struct packed {
		logic tick;
		logic load_int;
		logic load_dig;
		logic conv_step;
		logic conv_write;
		logic shift_step;
	} sssd_cmd_t;

	typedef struct packed {
		logic int_over;
		logic fire;
		logic conv_last;
		logic shift_last;
	} sssd_stat_t;

	// gfedcba numerals, dash for codes above nine
	function automatic seg_t seg_font(input logic [3:0] code);
		seg_t s;
		case (code)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = SEG_DASH;
		endcase
		return s;
	endfunction

	// largest value that fits in n digits, capped at 99999999
	function automatic logic [CONV_W-1:0] int_limit(input int n);
		longint p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		if (p > 100000000) begin
			p = 100000000;
		end
		return CONV_W'(p - 1);
	endfunction

endpackage

`default_nettype wire

@@ design/seven_segment_scan_driver_top.sv @@
// ---------------------------------------------------------------------------
// seven_segment_scan_driver_top
// Scan driver for a multiplexed seven-segment display behind two shift
// registers.
// ---------------------------------------------------------------------------
// Takes one word at a time. On a tick word (opcode 0), when the elapsed
// count passes the period register it starts a run of 16 output words,
// one per cycle while out_ready is high: the inverted digit-select byte then
// the segment byte, MSB first, latch_after marking the last. No new input is
// taken until the run is out. A digit-list word fills the segment store. A
// show-integer word runs a 27-step binary-to-BCD shifter, one bit per
// cycle, then a write state fills the segment store; values over the
// displayable range write O and L straight away. Segment bytes are gfedcba
// with the dot in bit 7. Configuration writes apply at once and are meant
// for idle periods only.
`default_nettype none

module seven_segment_scan_driver_top #(
	parameter int NUM_DIGITS = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire [19:0] cfg_wdata,
	// input words
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [1:0]  opcode,
	input  wire [31:0] value,
	input  wire [31:0] digit_codes,
	// output words, one per shift clock
	output logic       out_valid,
	input  wire        out_ready,
	output logic       serial_bit,
	output logic       latch_after,
	output logic [2:0] scan_digit
);
	import sssd_pkg::*;

	`include "assert_macros.svh"

	sssd_cmd_t  cmd;
	sssd_stat_t stat;

	// sequencer: handshakes and step commands
	sssd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// store, timer, converter and shifter
	sssd_dp #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.value       (value),
		.digit_codes (digit_codes),
		.cmd         (cmd),
		.stat        (stat),
		.serial_bit  (serial_bit),
		.latch_after (latch_after),
		.scan_digit  (scan_digit)
	);

	// one word in flight at a time
	`SSSD_NEVER(a_busy_overlap, in_ready && out_valid, "input taken during shift-out")
	// the latch word closes the run
	`SSSD_NEXT(a_run_end, out_valid && out_ready && latch_after, !out_valid,
		"shift-out ran past sixteen words")
	// a refreshing tick always opens a run
	`SSSD_NEXT(a_run_start, cmd.tick && stat.fire, out_valid && !latch_after,
		"refresh did not start a run")
	// never scan a position beyond the display
	`SSSD_NEVER(a_scan_range, out_valid && (32'(scan_digit) >= NUM_DIGITS),
		"scan position out of range")

endmodule

`default_nettype wire

@@ design/sssd_ctrl.sv @@
// ---------------------------------------------------------------------------
// sssd_ctrl
// Sequencer: input handshake, conversion steps and the shift-out run.
// ---------------------------------------------------------------------------
`default_nettype none

module sssd_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire [1:0]               opcode,
	output logic                    out_valid,
	input  wire                     out_ready,
	output sssd_pkg::sssd_cmd_t     cmd,
	input  sssd_pkg::sssd_stat_t    stat
);
	import sssd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CONV  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_SHIFT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SHIFT);
	assign acc       = in_valid && in_ready;

	always_comb begin
		cmd            = '0;
		cmd.tick       = acc && (opcode == OP_TICK);
		cmd.load_int   = acc && (opcode == OP_INT);
		cmd.load_dig   = acc && (opcode == OP_DIG);
		cmd.conv_step  = (state_q == ST_CONV);
		cmd.conv_write = (state_q == ST_WRITE);
		cmd.shift_step = (state_q == ST_SHIFT) && out_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.tick && stat.fire) begin
					state_d = ST_SHIFT;
				end else if (cmd.load_int && !stat.int_over) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (stat.conv_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_d = ST_IDLE;
			end
			ST_SHIFT: begin
				if (out_ready && stat.shift_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ design/sssd_dp.sv @@
// ---------------------------------------------------------------------------
// sssd_dp
// Datapath: registers, segment store, BCD converter, refresh timer, shifter.
// ---------------------------------------------------------------------------
`default_nettype none

module sssd_dp #(
	parameter int NUM_DIGITS = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire                         cfg_index,
	input  wire [sssd_pkg::PERIOD_W-1:0] cfg_wdata,
	input  wire [31:0]                  value,
	input  wire [31:0]                  digit_codes,
	input  sssd_pkg::sssd_cmd_t         cmd,
	output sssd_pkg::sssd_stat_t        stat,
	output logic                        serial_bit,
	output logic                        latch_after,
	output logic [sssd_pkg::POS_W-1:0]  scan_digit
);
	import sssd_pkg::*;

	localparam logic [CONV_W-1:0] LIMIT    = int_limit(NUM_DIGITS);
	localparam logic [POS_W-1:0]  LAST_POS = POS_W'(NUM_DIGITS - 1);

	logic [PERIOD_W-1:0]  period_q;
	logic [MASK_W-1:0]    mask_q;
	seg_t                 store_q [MAX_DIGITS];
	logic [POS_W-1:0]     scan_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [CONV_W-1:0]    bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [STEP_W-1:0]    step_q;
	logic [WORD_W-1:0]    word_q;
	logic [BITCNT_W-1:0]  bit_q;

	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [BCD_W-1:0]     bcd_adj;
	seg_t                 int_segs [MAX_DIGITS];
	seg_t                 dig_segs [MAX_DIGITS];
	logic [7:0]           sel_byte;

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	assign stat.fire       = elapsed_inc > {1'b0, period_q};
	assign stat.int_over   = value > {{(32 - CONV_W){1'b0}}, LIMIT};
	assign stat.conv_last  = (step_q == STEP_W'(CONV_W - 1));
	assign stat.shift_last = (bit_q == BITCNT_W'(WORD_W - 1));

	assign serial_bit  = word_q[WORD_W-1];
	assign latch_after = stat.shift_last;
	assign scan_digit  = scan_q;

	assign sel_byte = ~((8'd1 << scan_q) & mask_q);

	// add-3 correction of every digit ahead of the shift
	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++) begin
			bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ?
				bcd_q[4*k +: 4] + 4'd3 : bcd_q[4*k +: 4];
		end
	end

	// right-aligned digits, leading zeros blanked; ones digit always shown
	always_comb begin
		logic seen;
		logic [3:0] d;
		seen = 1'b0;
		d = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			int_segs[i] = '0;
		end
		for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
			if (k < NUM_DIGITS) begin
				d = bcd_q[4*k +: 4];
				seen = seen | (d != 4'd0);
				if (seen || k == 0) begin
					int_segs[POS_W'(NUM_DIGITS - 1 - k)] = seg_font(d);
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dig_segs[i] = (i < NUM_DIGITS) ? seg_font(digit_codes[4*i +: 4]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_W'(2083);
			mask_q   <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD: period_q <= cfg_wdata;
				REG_MASK:   mask_q   <= cfg_wdata[MASK_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				store_q[i] <= '0;
			end
		end else if (cmd.load_dig) begin
			store_q <= dig_segs;
		end else if (cmd.conv_write) begin
			store_q <= int_segs;
		end else if (cmd.load_int && stat.int_over) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				store_q[i] <= '0;
			end
			if (NUM_DIGITS >= 2) begin
				store_q[POS_W'(NUM_DIGITS - 2)] <= SEG_O;
			end
			store_q[LAST_POS] <= SEG_L;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (cmd.tick) begin
			elapsed_q <= stat.fire ? '0 : elapsed_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load_int) begin
			step_q <= '0;
		end else if (cmd.conv_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_int) begin
			bin_q <= value[CONV_W-1:0];
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			bin_q <= {bin_q[CONV_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[CONV_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			bit_q  <= '0;
		end else if (cmd.tick && stat.fire) begin
			bit_q <= '0;
		end else if (cmd.shift_step) begin
			bit_q <= bit_q + 1'b1;
			if (stat.shift_last) begin
				scan_q <= (scan_q == LAST_POS) ? '0 : scan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick && stat.fire) begin
			word_q <= {sel_byte, store_q[scan_q]};
		end else if (cmd.shift_step) begin
			word_q <= {word_q[WORD_W-2:0], 1'b0};
		end
	end

endmodule

`default_nettype wire
